// ===== rtl/core/hee_pkg.sv =====
// Shared types, constants and lookup functions for the HTML entity escaper.
// Depends on nothing; used by every module in rtl/core but hee_digits.
package hee_pkg;

  localparam int NameMax = 8;
  localparam int QDepth = 4;
  localparam int QAw = 2;

  typedef enum logic [2:0] {
    K_PASS,
    K_NAMED,
    K_BR,
    K_NBSP,
    K_TAB,
    K_DEC
  } kind_t;

  // One classified unit: what the back end needs to emit its run.
  typedef struct packed {
    kind_t            kind;
    logic [7:0]       pass_char;
    logic [3:0]       name_len;
    logic [NameMax*8-1:0] name;  // last character in the lowest byte, zeros above
    logic [4:0][3:0]  digits;    // digit 4 is the ten-thousands place
    logic [2:0]       first_digit;
  } job_t;

  localparam int QW = $bits(job_t);

  // Entity names for 0xA0 .. 0xFF, indexed by code - 0xA0.
  localparam logic [NameMax*8-1:0] Latin1Names [96] = '{
    "nbsp","iexcl","cent","pound","curren","yen","brvbar","sect",
    "uml","copy","ordf","laquo","not","shy","reg","macr",
    "deg","plusmn","sup2","sup3","acute","micro","para","middot",
    "cedil","sup1","ordm","raquo","frac14","frac12","frac34","iquest",
    "Agrave","Aacute","Acirc","Atilde","Auml","Aring","AElig","Ccedil",
    "Egrave","Eacute","Ecirc","Euml","Igrave","Iacute","Icirc","Iuml",
    "ETH","Ntilde","Ograve","Oacute","Ocirc","Otilde","Ouml","times",
    "Oslash","Ugrave","Uacute","Ucirc","Uuml","Yacute","THORN","szlig",
    "agrave","aacute","acirc","atilde","auml","aring","aelig","ccedil",
    "egrave","eacute","ecirc","euml","igrave","iacute","icirc","iuml",
    "eth","ntilde","ograve","oacute","ocirc","otilde","ouml","divide",
    "oslash","ugrave","uacute","ucirc","uuml","yacute","thorn","yuml"};

  function automatic logic [NameMax*8-1:0] latin1_name(input logic [6:0] i);
    return Latin1Names[i];
  endfunction

  // Number of characters in a name, counted from the highest nonzero byte.
  function automatic logic [3:0] name_length(input logic [NameMax*8-1:0] n);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < NameMax; i++) begin
      if (n[i*8 +: 8] != 8'd0) r = 4'(i + 1);
    end
    return r;
  endfunction

  function automatic logic [NameMax*8-1:0] other_name(input logic [15:0] c);
    case (c)
      16'h0022: return "quot";    16'h0026: return "amp";
      16'h003C: return "lt";      16'h003E: return "gt";
      16'h0152: return "OElig";   16'h0153: return "oelig";
      16'h0160: return "Scaron";  16'h0161: return "scaron";
      16'h0178: return "Yuml";    16'h0192: return "fnof";
      16'h02C6: return "circ";    16'h02DC: return "tilde";
      16'h0391: return "Alpha";   16'h0392: return "Beta";
      16'h0393: return "Gamma";   16'h0394: return "Delta";
      16'h0395: return "Epsilon"; 16'h0396: return "Zeta";
      16'h0397: return "Eta";     16'h0398: return "Theta";
      16'h0399: return "Iota";    16'h039A: return "Kappa";
      16'h039B: return "Lambda";  16'h039C: return "Mu";
      16'h039D: return "Nu";      16'h039E: return "Xi";
      16'h039F: return "Omicron"; 16'h03A0: return "Pi";
      16'h03A1: return "Rho";     16'h03A3: return "Sigma";
      16'h03A4: return "Tau";     16'h03A5: return "Upsilon";
      16'h03A6: return "Phi";     16'h03A7: return "Chi";
      16'h03A8: return "Psi";     16'h03A9: return "Omega";
      16'h03B1: return "alpha";   16'h03B2: return "beta";
      16'h03B3: return "gamma";   16'h03B4: return "delta";
      16'h03B5: return "epsilon"; 16'h03B6: return "zeta";
      16'h03B7: return "eta";     16'h03B8: return "theta";
      16'h03B9: return "iota";    16'h03BA: return "kappa";
      16'h03BB: return "lambda";  16'h03BC: return "mu";
      16'h03BD: return "nu";      16'h03BE: return "xi";
      16'h03BF: return "omicron"; 16'h03C0: return "pi";
      16'h03C1: return "rho";     16'h03C2: return "sigmaf";
      16'h03C3: return "sigma";   16'h03C4: return "tau";
      16'h03C5: return "upsilon"; 16'h03C6: return "phi";
      16'h03C7: return "chi";     16'h03C8: return "psi";
      16'h03C9: return "omega";   16'h03D1: return "thetasym";
      16'h03D2: return "upsih";   16'h03D6: return "piv";
      16'h2002: return "ensp";    16'h2003: return "emsp";
      16'h2009: return "thinsp";  16'h200C: return "zwnj";
      16'h200D: return "zwj";     16'h200E: return "lrm";
      16'h200F: return "rlm";     16'h2013: return "ndash";
      16'h2014: return "mdash";   16'h2018: return "lsquo";
      16'h2019: return "rsquo";   16'h201A: return "sbquo";
      16'h201C: return "ldquo";   16'h201D: return "rdquo";
      16'h201E: return "bdquo";   16'h2020: return "dagger";
      16'h2021: return "Dagger";  16'h2022: return "bull";
      16'h2026: return "hellip";  16'h2030: return "permil";
      16'h2032: return "prime";   16'h2033: return "Prime";
      16'h2039: return "lsaquo";  16'h203A: return "rsaquo";
      16'h203E: return "oline";   16'h2044: return "frasl";
      16'h20AC: return "euro";    16'h2111: return "image";
      16'h2118: return "weierp";  16'h211C: return "real";
      16'h2122: return "trade";   16'h2135: return "alefsym";
      16'h2190: return "larr";    16'h2191: return "uarr";
      16'h2192: return "rarr";    16'h2193: return "darr";
      16'h2194: return "harr";    16'h21B5: return "crarr";
      16'h21D0: return "lArr";    16'h21D1: return "uArr";
      16'h21D2: return "rArr";    16'h21D3: return "dArr";
      16'h21D4: return "hArr";    16'h2200: return "forall";
      16'h2202: return "part";    16'h2203: return "exist";
      16'h2205: return "empty";   16'h2207: return "nabla";
      16'h2208: return "isin";    16'h2209: return "notin";
      16'h220B: return "ni";      16'h220F: return "prod";
      16'h2211: return "sum";     16'h2212: return "minus";
      16'h2217: return "lowast";  16'h221A: return "radic";
      16'h221D: return "prop";    16'h221E: return "infin";
      16'h2220: return "ang";     16'h2227: return "and";
      16'h2228: return "or";      16'h2229: return "cap";
      16'h222A: return "cup";     16'h222B: return "int";
      16'h2234: return "there4";  16'h223C: return "sim";
      16'h2245: return "cong";    16'h2248: return "asymp";
      16'h2260: return "ne";      16'h2261: return "equiv";
      16'h2264: return "le";      16'h2265: return "ge";
      16'h2282: return "sub";     16'h2283: return "sup";
      16'h2284: return "nsub";    16'h2286: return "sube";
      16'h2287: return "supe";    16'h2295: return "oplus";
      16'h2297: return "otimes";  16'h22A5: return "perp";
      16'h22C5: return "sdot";    16'h2308: return "lceil";
      16'h2309: return "rceil";   16'h230A: return "lfloor";
      16'h230B: return "rfloor";  16'h2329: return "lang";
      16'h232A: return "rang";    16'h25CA: return "loz";
      16'h2660: return "spades";  16'h2663: return "clubs";
      16'h2665: return "hearts";  16'h2666: return "diams";
      default:  return '0;
    endcase
  endfunction

endpackage

// ===== rtl/core/hee_digits.sv =====
// Registered binary to decimal conversion of a 16-bit code unit.
// Self-contained; a two-stage double-dabble, eight shifts per stage.
module hee_digits (
  input  logic                  clk,
  input  logic                  en,
  input  logic [15:0]           value,
  output logic [4:0][3:0]       digits
);

  logic [19:0] bcd_mid;
  logic [7:0]  low_mid;
  logic [19:0] bcd_a;
  logic [19:0] bcd_b;

  function automatic logic [19:0] dabble8(input logic [19:0] b, input logic [7:0] v);
    logic [19:0] r;
    r = b;
    for (int s = 7; s >= 0; s--) begin
      for (int d = 0; d < 5; d++) begin
        if (r[d*4 +: 4] >= 4'd5) r[d*4 +: 4] = r[d*4 +: 4] + 4'd3;
      end
      r = {r[18:0], v[s]};
    end
    return r;
  endfunction

  assign bcd_a = dabble8(20'd0, value[15:8]);
  assign bcd_b = dabble8(bcd_mid, low_mid);

  always_ff @(posedge clk) begin
    if (en) begin
      bcd_mid <= bcd_a;
      low_mid <= value[7:0];
    end
  end

  always_comb begin
    for (int d = 0; d < 5; d++) digits[d] = bcd_b[d*4 +: 4];
  end

endmodule

// ===== rtl/core/hee_front.sv =====
// Front end: accepts code units, classifies them and builds one job each.
// Uses hee_pkg and hee_digits.
module hee_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [2:0]        opts,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_unit,
  output logic              job_valid,
  input  logic              job_ready,
  output hee_pkg::job_t     job
);

  // Two registered stages; the digit conversion spans both.
  logic           s1_valid;
  logic [15:0]    s1_unit;
  hee_pkg::job_t  s1_job;
  logic           s2_valid;
  hee_pkg::job_t  s2_job;
  hee_pkg::job_t  s2_job_next;
  logic [4:0][3:0] dig;
  logic           adv2;
  logic           adv1;
  hee_pkg::job_t  cls;
  logic [hee_pkg::NameMax*8-1:0] nm;

  assign adv2 = !s2_valid || job_ready;
  assign adv1 = !s1_valid || adv2;
  assign in_ready = adv1;

  always_comb begin
    nm = (in_unit >= 16'h00A0 && in_unit <= 16'h00FF) ?
         hee_pkg::latin1_name(7'(in_unit - 16'h00A0)) : hee_pkg::other_name(in_unit);
    cls = '0;
    cls.pass_char = in_unit[7:0];
    cls.name = nm;
    cls.name_len = hee_pkg::name_length(nm);
    if (nm != '0)                                cls.kind = hee_pkg::K_NAMED;
    else if (opts[0] && in_unit == 16'h000A)     cls.kind = hee_pkg::K_BR;
    else if (opts[1] && in_unit == 16'h0020)     cls.kind = hee_pkg::K_NBSP;
    else if (opts[2] && in_unit == 16'h0009)     cls.kind = hee_pkg::K_TAB;
    else if (in_unit > 16'h00FF)                 cls.kind = hee_pkg::K_DEC;
    else                                         cls.kind = hee_pkg::K_PASS;
  end

  hee_digits u_digits (
    .clk    (clk),
    .en     (adv1),
    .value  (in_unit),
    .digits (dig)
  );

  always_comb begin
    s2_job_next = s1_job;
    s2_job_next.digits = dig;
    if (s1_unit >= 16'd10000)     s2_job_next.first_digit = 3'd4;
    else if (s1_unit >= 16'd1000) s2_job_next.first_digit = 3'd3;
    else                          s2_job_next.first_digit = 3'd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= in_valid;
      if (adv2) s2_valid <= s1_valid;
    end
    if (adv1) begin
      s1_job  <= cls;
      s1_unit <= in_unit;
    end
    if (adv2) begin
      s2_job <= s2_job_next;
    end
  end

  assign job_valid = s2_valid;
  assign job = s2_job;

endmodule

// ===== rtl/core/hee_queue.sv =====
// Short FIFO of classified jobs between the front and back ends.
// Uses hee_pkg.
module hee_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  hee_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_ready,
  output hee_pkg::job_t rd_job
);

  hee_pkg::job_t            mem [hee_pkg::QDepth];
  logic [hee_pkg::QAw-1:0]  wp;
  logic [hee_pkg::QAw-1:0]  rp;
  logic [hee_pkg::QAw:0]    cnt;
  logic                     wr;
  logic                     rd;

  assign wr_ready = cnt != (hee_pkg::QAw+1)'(hee_pkg::QDepth);
  assign rd_valid = cnt != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_job = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + (hee_pkg::QAw+1)'(wr) - (hee_pkg::QAw+1)'(rd);
    end
    if (wr) mem[wp] <= wr_job;
  end

`ifndef ASSERT_OFF
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    cnt <= (hee_pkg::QAw+1)'(hee_pkg::QDepth)) else $error("queue overflow");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0 || cnt == (hee_pkg::QAw+1)'(hee_pkg::QDepth)) |-> wp == rp)
    else $error("queue pointers disagree with count");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> cnt == $past(cnt) + 1'b1) else $error("count did not rise");
`endif

endmodule

// ===== rtl/core/hee_back.sv =====
// Back end: walks one job's character run and drives the output register.
// Uses hee_pkg.
module hee_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  hee_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          out_last
);

  logic [5:0] pos;
  logic [2:0] ph;
  logic [5:0] len;
  logic [7:0] ch;
  logic [2:0] di;
  logic [2:0] k;
  logic       adv;
  logic       fin;

  always_comb begin
    ch = 8'h3F;
    len = 6'd1;
    di = 3'd0;
    k = 3'd0;
    case (job.kind)
      hee_pkg::K_PASS: ch = job.pass_char;
      hee_pkg::K_NAMED: begin
        len = 6'(job.name_len) + 6'd2;
        if (pos == 6'd0) ch = "&";
        else if (pos == len - 6'd1) ch = ";";
        else ch = job.name[3'(6'(job.name_len) - pos)*8 +: 8];
      end
      hee_pkg::K_BR: begin
        len = 6'd5;
        case (pos[2:0])
          3'd0: ch = "<";
          3'd1: ch = "B";
          3'd2: ch = "R";
          3'd3: ch = ">";
          default: ch = 8'h0A;
        endcase
      end
      hee_pkg::K_NBSP, hee_pkg::K_TAB: begin
        len = (job.kind == hee_pkg::K_TAB) ? 6'd48 : 6'd6;
        case (ph)
          3'd0: ch = "&";
          3'd1: ch = "n";
          3'd2: ch = "b";
          3'd3: ch = "s";
          3'd4: ch = "p";
          default: ch = ";";
        endcase
      end
      hee_pkg::K_DEC: begin
        len = 6'(job.first_digit) + 6'd4;
        if (pos == 6'd0) ch = "&";
        else if (pos == 6'd1) ch = "#";
        else if (pos == len - 6'd1) ch = ";";
        else begin
          k = 3'(pos - 6'd2);
          di = job.first_digit - k;
          ch = {4'h3, job.digits[di]};
        end
      end
      default: ch = job.pass_char;
    endcase
  end

  assign adv = !out_valid || out_ready;
  assign fin = pos == len - 6'd1;
  assign job_ready = adv && fin;

  // ph tracks the position within one six-character no-break space entity.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      ph <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= job_valid;
      if (job_valid) begin
        pos <= fin ? 6'd0 : pos + 6'd1;
        ph <= (fin || ph == 3'd5) ? 3'd0 : ph + 3'd1;
      end
    end
    if (adv && job_valid) begin
      out_char <= ch;
      out_last <= fin;
    end
  end

`ifndef ASSERT_OFF
  a_pos: assert property (@(posedge clk) disable iff (rst)
    !job_valid || pos < len) else $error("run position past its length");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_char) && $stable(out_last))
    else $error("stalled character changed");
  a_last: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job_ready) |-> fin) else $error("job retired mid-run");
`endif

endmodule

// ===== rtl/core/html_entity_escaper.sv =====
// Top level of the HTML entity escaper: configuration register, front end,
// job queue and back end. Uses hee_pkg and the hee_* modules.
//
// Usage: code units enter on the s_axis channel (tdata bits 15:0 hold
// code_unit). Each unit becomes a run of 1 to 48 characters on m_axis
// (tdata bits 7:0 hold out_char); tlast marks the final character of a run.
// cfg writes the 3-bit escape_options register (bit0 newline to BR, bit1
// space to nbsp, bit2 tab to eight nbsp); it is always ready and should be
// written only while the block is idle.
// After a unit is accepted, its job passes the second classify stage and the
// job queue before its first character is loaded into the output register.
// Throughput: while m_axis_tready stays high, the back end emits one
// character per cycle; plain characters stream one per cycle. The front
// end keeps accepting until the four-entry job queue and both stages fill.
// Reset clears the options to zero and empties every stage.
// When the receiver stalls, the output word holds and the back end, queue
// and front end fill in turn before s_axis_tready falls.
module html_entity_escaper (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,        // escape_options
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // [15:0] code_unit
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // [7:0] out_char
  output logic        m_axis_tlast     // run_last
);

  logic [2:0]    opts;
  logic          fj_valid;
  logic          fj_ready;
  hee_pkg::job_t fj;
  logic          bj_valid;
  logic          bj_ready;
  hee_pkg::job_t bj;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) opts <= '0;
    else if (cfg_valid) opts <= cfg_data;
  end

  hee_front u_front (
    .clk (clk), .rst (rst), .opts (opts),
    .in_valid (s_axis_tvalid), .in_ready (s_axis_tready), .in_unit (s_axis_tdata),
    .job_valid (fj_valid), .job_ready (fj_ready), .job (fj)
  );

  hee_queue u_queue (
    .clk (clk), .rst (rst),
    .wr_valid (fj_valid), .wr_ready (fj_ready), .wr_job (fj),
    .rd_valid (bj_valid), .rd_ready (bj_ready), .rd_job (bj)
  );

  hee_back u_back (
    .clk (clk), .rst (rst),
    .job_valid (bj_valid), .job_ready (bj_ready), .job (bj),
    .out_valid (m_axis_tvalid), .out_ready (m_axis_tready),
    .out_char (m_axis_tdata), .out_last (m_axis_tlast)
  );

endmodule
